[rtl/core/mono_framebuffer_pixel_span_writer_top_macros.svh]
// Assertion macros shared by the checker of the span writer.
`ifndef MONO_FRAMEBUFFER_PIXEL_SPAN_WRITER_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_PIXEL_SPAN_WRITER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define MFPSW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define MFPSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mfpsw_pkg.sv]
// Shared types and constants of the framebuffer span writer.
package mfpsw_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SPAN  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam int          MAX_BYTES  = 40;
    localparam int          CNT_W      = 6;
    localparam logic [7:0]  FULL_BYTE  = 8'hff;
    localparam logic [7:0]  LEFT_PIXEL = 8'h80;

    typedef enum logic [2:0] {
        E_READ,
        E_SINGLE,
        E_HEAD,
        E_MID,
        E_LAST
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  calc;
        logic  reduce;
        logic  rd;
        logic  emit;
        t_emit emit_kind;
        logic  clear;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic is_read;
        logic is_span;
        logic single;
        logic addr_ok;
        logic cnt_one;
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

[rtl/core/mfpsw_datapath.sv]
// Datapath: item registers, address arithmetic, frame store and result register.
module mfpsw_datapath #(
    parameter int BYTES_PER_ROW = 40,
    parameter int ROWS          = 240,
    parameter int PAGE_STRIDE   = 9600
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mfpsw_pkg::t_cmd       i_cmd,
    output mfpsw_pkg::t_status    o_status,
    input  logic [1:0]            i_op,
    input  logic [8:0]            i_x,
    input  logic [7:0]            i_y,
    input  logic [8:0]            i_x_end,
    input  logic                  i_color,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_screen_page,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_kind,
    output logic [14:0]           o_byte_address,
    output logic [7:0]            o_byte_data,
    output logic                  o_pixel_value,
    output logic                  o_last
);

    localparam int STORE    = 2 * PAGE_STRIDE;
    localparam int ADDR_W   = $clog2(STORE);
    localparam int RAW_W    = $clog2(2 * PAGE_STRIDE + 256 * BYTES_PER_ROW + 64);
    localparam int K_W      = $clog2(RAW_W);
    localparam int WIDTH_PX = BYTES_PER_ROW * 8;
    localparam int CMP_W    = 11;

    logic [1:0]                  r_op;
    logic [8:0]                  r_x;
    logic [7:0]                  r_y;
    logic [8:0]                  r_xe;
    logic                        r_color;
    logic                        r_page;
    logic [RAW_W-1:0]            r_addr;
    logic [K_W-1:0]              r_k;
    logic [mfpsw_pkg::CNT_W-1:0] r_cnt;
    logic [7:0]                  r_rdata;
    logic [ADDR_W-1:0]           r_clr;
    logic [7:0]                  r_store [STORE];

    logic                        r_out_valid;
    logic                        r_kind;
    logic [14:0]                 r_baddr;
    logic [7:0]                  r_bdata;
    logic                        r_pix;
    logic                        r_last;

    logic [RAW_W-1:0]            n_raw;
    logic [RAW_W-1:0]            n_addr_inc;
    logic [RAW_W-1:0]            n_red_sub;
    logic                        n_red_hit;
    logic [mfpsw_pkg::CNT_W-1:0] n_span;
    logic [mfpsw_pkg::CNT_W-1:0] n_span_cap;
    logic [7:0]                  n_pmask;
    logic [7:0]                  n_head;
    logic [7:0]                  n_tail;
    logic [7:0]                  n_mask;
    logic [7:0]                  n_byte;
    logic                        n_drop;
    logic [ADDR_W-1:0]           n_idx;

    assign n_idx = r_addr[ADDR_W-1:0];

    always_comb begin
        n_drop = (r_op == mfpsw_pkg::OP_NONE)
              || ({2'b00, r_x} >= CMP_W'(WIDTH_PX))
              || ({3'b000, r_y} >= CMP_W'(ROWS))
              || ((r_op == mfpsw_pkg::OP_SPAN)
                  && (({2'b00, r_xe} >= CMP_W'(WIDTH_PX)) || (r_xe < r_x)));
    end

    always_comb begin
        n_raw = (r_page ? RAW_W'(PAGE_STRIDE) : '0)
              + (RAW_W'(r_y) * RAW_W'(BYTES_PER_ROW))
              + RAW_W'(r_x[8:3]);
        n_addr_inc = (r_addr == RAW_W'(STORE - 1)) ? '0 : r_addr + 1'b1;
        // One step of the shift-and-subtract reduction modulo the store size.
        n_red_hit  = (r_addr >> r_k) >= RAW_W'(STORE);
        n_red_sub  = r_addr - (RAW_W'(STORE) << r_k);
    end

    always_comb begin
        n_span     = r_xe[8:3] - r_x[8:3];
        n_span_cap = (n_span > mfpsw_pkg::CNT_W'(mfpsw_pkg::MAX_BYTES - 1))
                   ? mfpsw_pkg::CNT_W'(mfpsw_pkg::MAX_BYTES - 1) : n_span;
        n_pmask    = mfpsw_pkg::LEFT_PIXEL >> r_x[2:0];
        n_head     = mfpsw_pkg::FULL_BYTE >> r_x[2:0];
        n_tail     = mfpsw_pkg::FULL_BYTE << (3'd7 - r_xe[2:0]);
    end

    always_comb begin
        case (i_cmd.emit_kind)
            mfpsw_pkg::E_SINGLE: begin
                n_mask = (r_op == mfpsw_pkg::OP_SPAN) ? (n_head & n_tail) : n_pmask;
            end
            mfpsw_pkg::E_HEAD: begin
                n_mask = n_head;
            end
            mfpsw_pkg::E_LAST: begin
                n_mask = n_tail;
            end
            mfpsw_pkg::E_MID: begin
                n_mask = mfpsw_pkg::FULL_BYTE;
            end
            default: begin
                n_mask = n_pmask;
            end
        endcase
        n_byte = r_color ? (r_rdata | n_mask) : (r_rdata & ~n_mask);
        if (i_cmd.emit_kind == mfpsw_pkg::E_MID) begin
            n_byte = r_color ? mfpsw_pkg::FULL_BYTE : 8'h00;
        end
    end

    always_comb begin
        o_status.drop     = n_drop;
        o_status.is_read  = (r_op == mfpsw_pkg::OP_READ);
        o_status.is_span  = (r_op == mfpsw_pkg::OP_SPAN);
        o_status.single   = (r_cnt == '0);
        o_status.addr_ok  = (r_addr < RAW_W'(STORE));
        o_status.cnt_one  = (r_cnt == mfpsw_pkg::CNT_W'(1));
        o_status.clr_last = (r_clr == ADDR_W'(STORE - 1));
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    // Item fields, address and span counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_x     <= i_x;
            r_y     <= i_y;
            r_xe    <= i_x_end;
            r_color <= i_color;
        end
        if (i_cmd.calc) begin
            r_addr <= n_raw;
            r_k    <= K_W'(RAW_W - 1);
            r_cnt  <= n_span_cap;
        end else if (i_cmd.reduce) begin
            if (n_red_hit) begin
                r_addr <= n_red_sub;
            end
            r_k <= r_k - 1'b1;
        end else if (i_cmd.emit) begin
            r_addr <= n_addr_inc;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= 1'b0;
            r_clr  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_page <= i_cfg_screen_page;
            end
            if (i_cmd.clear) begin
                r_clr <= o_status.clr_last ? '0 : r_clr + 1'b1;
            end
        end
    end

    // Frame store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_store[r_clr] <= 8'h00;
        end else if (i_cmd.emit && (i_cmd.emit_kind != mfpsw_pkg::E_READ)) begin
            r_store[n_idx] <= n_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_store[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_baddr <= 15'(r_addr);
            if (i_cmd.emit_kind == mfpsw_pkg::E_READ) begin
                r_kind  <= mfpsw_pkg::KIND_READ;
                r_bdata <= r_rdata;
                r_pix   <= |(r_rdata & n_pmask);
            end else begin
                r_kind  <= mfpsw_pkg::KIND_WRITE;
                r_bdata <= n_byte;
                r_pix   <= 1'b0;
            end
            r_last <= (i_cmd.emit_kind == mfpsw_pkg::E_READ)
                   || (i_cmd.emit_kind == mfpsw_pkg::E_SINGLE)
                   || (i_cmd.emit_kind == mfpsw_pkg::E_LAST);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_byte_address = r_baddr;
    assign o_byte_data    = r_bdata;
    assign o_pixel_value  = r_pix;
    assign o_last         = r_last;

endmodule

[rtl/core/mfpsw_controller.sv]
// Controller: sequences clearing, address reduction, reads and result beats.
module mfpsw_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mfpsw_pkg::t_status i_status,
    output mfpsw_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_REDUCE,
        ST_FIRST,
        ST_MID,
        ST_LREAD,
        ST_LAST
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.emit_kind = mfpsw_pkg::E_READ;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_status.drop ? ST_IDLE : ST_REDUCE;
            end
            ST_REDUCE: begin
                // The read is issued once the address lies inside the store.
                if (i_status.addr_ok) begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_FIRST;
                end else begin
                    o_cmd.reduce = 1'b1;
                end
            end
            ST_FIRST: begin
                if (i_status.is_read) begin
                    o_cmd.emit_kind = mfpsw_pkg::E_READ;
                end else if (!i_status.is_span || i_status.single) begin
                    o_cmd.emit_kind = mfpsw_pkg::E_SINGLE;
                end else begin
                    o_cmd.emit_kind = mfpsw_pkg::E_HEAD;
                end
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_status.is_span || i_status.single) begin
                        n_state = ST_IDLE;
                    end else if (i_status.cnt_one) begin
                        n_state = ST_LREAD;
                    end else begin
                        n_state = ST_MID;
                    end
                end
            end
            ST_MID: begin
                o_cmd.emit_kind = mfpsw_pkg::E_MID;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.cnt_one) begin
                        n_state = ST_LREAD;
                    end
                end
            end
            ST_LREAD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_LAST;
            end
            ST_LAST: begin
                o_cmd.emit_kind = mfpsw_pkg::E_LAST;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

[rtl/core/mono_framebuffer_pixel_span_writer_top.sv]
// Pixel read/write: address computed, store byte read, then the result beat is registered;
// a new item is accepted only after the last beat of the previous one is emitted. Span of n
// bytes: head beat, then one beat a cycle between the edges unless the output stalls, one extra
// store read for the tail byte; a span within one byte runs like a pixel. An address past the
// store adds up to one reduction step per address bit (none with the default geometry).
// Reset is synchronous and active low; afterwards all 2 * PAGE_STRIDE bytes of the
// frame store (19200 by default) are zeroed with input ready held low.
module mono_framebuffer_pixel_span_writer_top #(
    parameter int BYTES_PER_ROW = 40,
    parameter int ROWS          = 240,
    parameter int PAGE_STRIDE   = 9600
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [8:0]  i_x,
    input  logic [7:0]  i_y,
    input  logic [8:0]  i_x_end,
    input  logic        i_color,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [14:0] o_byte_address,
    output logic [7:0]  o_byte_data,
    output logic        o_pixel_value,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_screen_page
);

    mfpsw_pkg::t_cmd    w_cmd;
    mfpsw_pkg::t_status w_status;

    // The page register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    mfpsw_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mfpsw_datapath #(
        .BYTES_PER_ROW (BYTES_PER_ROW),
        .ROWS          (ROWS),
        .PAGE_STRIDE   (PAGE_STRIDE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_op              (i_op),
        .i_x               (i_x),
        .i_y               (i_y),
        .i_x_end           (i_x_end),
        .i_color           (i_color),
        .i_cfg_valid       (i_cfg_valid & o_cfg_ready),
        .i_cfg_screen_page (i_cfg_screen_page),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_byte_address    (o_byte_address),
        .o_byte_data       (o_byte_data),
        .o_pixel_value     (o_pixel_value),
        .o_last            (o_last)
    );

endmodule

[rtl/core/mfpsw_checker.sv]
// Port-level checker of the span writer, bound to the top level.
`include "mono_framebuffer_pixel_span_writer_top_macros.svh"

module mfpsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_kind,
    input logic [14:0] o_byte_address,
    input logic [7:0]  o_byte_data,
    input logic        o_pixel_value,
    input logic        o_last
);

    `MFPSW_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result beat dropped while stalled")
    `MFPSW_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_byte_address) && $stable(o_byte_data) && $stable(o_kind) && $stable(o_last), "stalled result beat changed")
    `MFPSW_ASSERT_NOW(a_write_no_pixel, o_out_valid && (o_kind == mfpsw_pkg::KIND_WRITE), !o_pixel_value, "write beat carries a pixel value")
    `MFPSW_ASSERT_NOW(a_read_is_last, o_out_valid && (o_kind == mfpsw_pkg::KIND_READ), o_last, "read answer not marked last")

endmodule

bind mono_framebuffer_pixel_span_writer_top mfpsw_checker u_chk (.*);
